// File: rtl/lrgd_pkg.sv
// Package for the linear regression gradient descent block.
// Holds reset values, field widths and the saturating fixed-point helpers.
// No dependencies.
`timescale 1ns / 1ps
package lrgd_pkg;

  localparam int unsigned VAL_W    = 48;
  localparam int unsigned LR_W     = 33;
  localparam int unsigned ITER_W   = 20;
  localparam int unsigned PROD_W   = 112;

  localparam int unsigned DEF_MAX_SAMPLES = 256;
  localparam int unsigned DEF_N_COEF      = 4;

  localparam logic [LR_W-1:0]   LR_RESET   = 33'd429496730;
  localparam logic [ITER_W-1:0] ITER_RESET = 20'd100000;
  localparam logic [LR_W-1:0]   TOL_RESET  = 33'd4295;

  localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
  localparam logic [1:0] CFG_MAX_ITER  = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE = 2'd2;

  localparam logic [1:0] KIND_FEATURE = 2'd0;
  localparam logic [1:0] KIND_TARGET  = 2'd1;
  localparam logic [1:0] KIND_WEIGHT  = 2'd2;
  localparam logic [1:0] KIND_START   = 2'd3;

  localparam logic signed [65:0] MAX48 = (66'sd1 <<< 47) - 66'sd1;
  localparam logic signed [65:0] MIN48 = -(66'sd1 <<< 47);
  localparam logic signed [65:0] MAX64 = (66'sd1 <<< 63) - 66'sd1;
  localparam logic signed [65:0] MIN64 = -(66'sd1 <<< 63);

  function automatic logic [47:0] sat48(input logic signed [65:0] s);
    logic [47:0] r;
    if (s > MAX48) r = 48'h7FFF_FFFF_FFFF;
    else if (s < MIN48) r = 48'h8000_0000_0000;
    else r = s[47:0];
    return r;
  endfunction

  function automatic logic [63:0] sat64(input logic signed [65:0] s);
    logic [63:0] r;
    if (s > MAX64) r = 64'h7FFF_FFFF_FFFF_FFFF;
    else if (s < MIN64) r = 64'h8000_0000_0000_0000;
    else r = s[63:0];
    return r;
  endfunction

  function automatic logic [47:0] abs48(input logic [47:0] v);
    return v[47] ? (48'd0 - v) : v;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// File: rtl/linear_regression_gradient_descent.sv
// Top level of the batch gradient descent engine for linear regression.
// Depends on lrgd_pkg, lrgd_mul and lrgd_div.
//
// Input words on the s_axis channel: tuser holds the kind, tdata the index and
// value. Feature, target and weight words are taken one per cycle; a target word
// writes the current feature row and target as one row while the memory has room.
// A start word runs gradient descent and the block drops tready until the weights
// are delivered. Each sample in an iteration reads its row, then forms the
// hypothesis and the gradient terms on the shared 16-bit-digit multiplier; the
// weight update divides each gradient by the sample count on the serial divider
// and scales it by the rate on the multiplier, and every iteration adds bookkeeping.
// The result is N_COEF words on m_axis, tlast on the last one; a stalled
// receiver simply holds the current word, and the sample count is cleared once the
// last word is taken. Reset zeroes weights and the sample count and loads the
// default configuration; the sample memory has no reset and needs none, as only
// written rows are read. Configuration writes are always accepted.
`timescale 1ns / 1ps
module linear_regression_gradient_descent import lrgd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int unsigned N_COEF      = DEF_N_COEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [32:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // index [3:0], value [51:4], zero [55:52]
  input  logic [55:0] s_axis_tdata_i,
  // kind [1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // weight_index [3:0], weight_value [51:4], iterations_used [71:52],
  // converged [72], zero [79:73]
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned NF     = N_COEF - 1;
  localparam int unsigned KW     = $clog2(N_COEF);
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ITER  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_HMUL  = 4'd3;
  localparam logic [3:0] S_HWAIT = 4'd4;
  localparam logic [3:0] S_ERR   = 4'd5;
  localparam logic [3:0] S_GMUL  = 4'd6;
  localparam logic [3:0] S_GWAIT = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DIVW  = 4'd9;
  localparam logic [3:0] S_SMUL  = 4'd10;
  localparam logic [3:0] S_SWAIT = 4'd11;
  localparam logic [3:0] S_CHK   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam logic [KW-1:0] K_LAST = KW'(N_COEF - 1);

  // Row layout: features in slots 0..NF-1, target in slot NF.
  logic [N_COEF-1:0][47:0] mem_q [MAX_SAMPLES];
  logic [N_COEF-1:0][47:0] row_q;
  logic [NF-1:0][47:0]     rowf_q;

  logic [LR_W-1:0]   lr_q, tol_q;
  logic [ITER_W-1:0] maxit_q, iters_q;
  logic [3:0]        state_q;
  logic [KW-1:0]     k_q;
  logic [CNT_W-1:0]  count_q, j_q;
  logic [47:0]       w_q [N_COEF];
  logic [63:0]       g_q [N_COEF];
  logic [47:0]       h_q, err_q;
  logic [63:0]       am_q;
  logic              within_q, conv_q;

  logic              in_acc, out_acc;
  logic [1:0]        kind;
  logic [3:0]        idx;
  logic [47:0]       val;
  logic              wr_row;
  logic              rd_en;

  logic              mul_start, mul_done;
  logic [63:0]       mul_a;
  logic [47:0]       mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              div_start, div_done;
  logic [63:0]       div_q;

  logic [47:0]       xk;
  logic [63:0]       qmag, qprod;
  logic              qneg;
  logic [80:0]       smag_r;
  logic [47:0]       smag, step;
  logic              sneg;

  assign kind = s_axis_tuser_i;
  assign idx  = s_axis_tdata_i[3:0];
  assign val  = s_axis_tdata_i[51:4];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  assign wr_row = in_acc && (kind == KIND_TARGET) && (count_q < CNT_W'(MAX_SAMPLES));
  assign rd_en  = (state_q == S_RD);

  always_ff @(posedge clk_i) begin
    if (wr_row) mem_q[count_q[ADDR_W-1:0]] <= {val, rowf_q};
    if (rd_en) row_q <= mem_q[j_q[ADDR_W-1:0]];
  end

  // Feature x[k-1] of the current row.
  assign xk = row_q[k_q - KW'(1)];

  always_comb begin
    mul_start = (state_q == S_HMUL) || (state_q == S_GMUL) || (state_q == S_SMUL);
    mul_a     = {16'd0, abs48(w_q[k_q])};
    mul_b     = abs48(xk);
    qneg      = w_q[k_q][47] ^ xk[47];
    if ((state_q == S_GMUL) || (state_q == S_GWAIT)) begin
      mul_a = {16'd0, abs48(err_q)};
      qneg  = err_q[47] ^ xk[47];
    end else if (state_q == S_SMUL) begin
      mul_a = am_q;
      mul_b = {15'd0, lr_q};
    end
  end

  // The multiplier holds its operands, so the sign is taken again when done.
  always_comb begin
    qmag  = mul_p[95:32] + {63'd0, mul_p[31]};
    qprod = qneg ? (64'd0 - qmag) : qmag;
  end

  // Step = -rate * average, magnitude clamped to the 48-bit range.
  always_comb begin
    smag_r = {1'b0, mul_p[111:32]} + {80'd0, mul_p[31]};
    sneg   = ~g_q[k_q][63];
    if (sneg) smag = (smag_r > 81'h8000_0000_0000) ? 48'h8000_0000_0000 : smag_r[47:0];
    else      smag = (smag_r > 81'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : smag_r[47:0];
    step   = sneg ? (48'd0 - smag) : smag;
  end

  assign div_start = (state_q == S_DIV);

  lrgd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  lrgd_div #(.DW(CNT_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (abs64(g_q[k_q])),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= LR_RESET;
      maxit_q <= ITER_RESET;
      tol_q   <= TOL_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_STEP_SIZE: lr_q    <= cfg_data_i;
        CFG_MAX_ITER:  maxit_q <= cfg_data_i[ITER_W-1:0];
        CFG_TOLERANCE: tol_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      j_q      <= '0;
      count_q  <= '0;
      iters_q  <= '0;
      within_q <= 1'b0;
      conv_q   <= 1'b0;
      rowf_q   <= '0;
      h_q      <= '0;
      err_q    <= '0;
      am_q     <= '0;
      for (int i = 0; i < N_COEF; i++) begin
        w_q[i] <= '0;
        g_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (kind)
              KIND_FEATURE: if ({1'b0, idx} < 5'(NF)) rowf_q[idx[KW-1:0]] <= val;
              KIND_TARGET:  if (wr_row) count_q <= count_q + CNT_W'(1);
              KIND_WEIGHT:  if ({1'b0, idx} < 5'(N_COEF)) w_q[idx[KW-1:0]] <= val;
              KIND_START: begin
                iters_q <= '0;
                conv_q  <= 1'b0;
                k_q     <= '0;
                if (count_q == '0 || maxit_q == '0) state_q <= S_OUT;
                else state_q <= S_ITER;
              end
              default: ;
            endcase
          end
        end
        S_ITER: begin
          iters_q <= iters_q + ITER_W'(1);
          for (int i = 0; i < N_COEF; i++) g_q[i] <= '0;
          j_q     <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          h_q     <= w_q[0];
          k_q     <= KW'(1);
          state_q <= S_HMUL;
        end
        S_HMUL: state_q <= S_HWAIT;
        S_HWAIT: begin
          if (mul_done) begin
            h_q <= sat48(66'(signed'(h_q)) + 66'(signed'(qprod)));
            if (k_q == K_LAST) state_q <= S_ERR;
            else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_HMUL;
            end
          end
        end
        S_ERR: begin
          err_q   <= sat48(66'(signed'(h_q)) - 66'(signed'(row_q[NF])));
          g_q[0]  <= sat64(66'(signed'(g_q[0])) +
                           66'(signed'(sat48(66'(signed'(h_q)) - 66'(signed'(row_q[NF]))))));
          k_q     <= KW'(1);
          state_q <= S_GMUL;
        end
        S_GMUL: state_q <= S_GWAIT;
        S_GWAIT: begin
          if (mul_done) begin
            g_q[k_q] <= sat64(66'(signed'(g_q[k_q])) + 66'(signed'(qprod)));
            if (k_q == K_LAST) begin
              if (j_q + CNT_W'(1) == count_q) begin
                k_q      <= '0;
                within_q <= 1'b1;
                state_q  <= S_DIV;
              end else begin
                j_q     <= j_q + CNT_W'(1);
                state_q <= S_RD;
              end
            end else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_GMUL;
            end
          end
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            am_q    <= div_q;
            state_q <= S_SMUL;
          end
        end
        S_SMUL: state_q <= S_SWAIT;
        S_SWAIT: begin
          if (mul_done) begin
            w_q[k_q] <= sat48(66'(signed'(w_q[k_q])) + 66'(signed'(step)));
            if (smag > {15'd0, tol_q}) within_q <= 1'b0;
            if (k_q == K_LAST) state_q <= S_CHK;
            else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_DIV;
            end
          end
        end
        S_CHK: begin
          k_q <= '0;
          if (within_q) begin
            conv_q  <= 1'b1;
            state_q <= S_OUT;
          end else if (iters_q == maxit_q) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_ITER;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (k_q == K_LAST) begin
              count_q <= '0;
              k_q     <= '0;
              state_q <= S_IDLE;
            end else begin
              k_q <= k_q + KW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata_o = {7'd0, conv_q, iters_q, w_q[k_q], 4'(k_q)};
  assign m_axis_tlast_o = (k_q == K_LAST);

endmodule

// File: rtl/lrgd_mul.sv
// Iterative unsigned multiplier, 64 by 48 bits, one 16-bit digit per cycle.
// Uses lrgd_pkg for the product width.
`timescale 1ns / 1ps
module lrgd_mul import lrgd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       a_i,
  input  logic [47:0]       b_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  logic [63:0]       a_q;
  logic [47:0]       b_q;
  logic [PROD_W-1:0] acc_q;
  logic [1:0]        cnt_q;
  logic              busy_q, done_q;
  logic [79:0]       part;
  logic [PROD_W-1:0] part_sh;

  assign part    = a_q * b_q[15:0];
  assign part_sh = {32'd0, part} << {cnt_q, 4'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd2) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + part_sh;
      b_q   <= {16'd0, b_q[47:16]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/lrgd_div.sv
// Restoring divider, 64-bit dividend by a narrow divisor, one quotient bit a cycle.
// Uses lrgd_pkg only through the common import.
`timescale 1ns / 1ps
module lrgd_div import lrgd_pkg::*; #(
  parameter int unsigned DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [63:0]   quot_o
);

  logic [63:0]   quot_q;
  logic [DW-1:0] rem_q, div_q;
  logic [5:0]    cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   r_sh, r_sub;
  logic          fit;

  assign r_sh  = {rem_q, quot_q[63]};
  assign r_sub = r_sh - {1'b0, div_q};
  assign fit   = (r_sh >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fit ? r_sub[DW-1:0] : r_sh[DW-1:0];
      quot_q <= {quot_q[62:0], fit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: bench/testbench.sv
// Self-checking bench for the linear regression gradient descent engine.
// Needs lrgd_pkg and the top level with its submodules; predicts every weight word
// with its own fixed-point descent model and compares the output stream against it.
`timescale 1ns / 1ps
module testbench;
  import lrgd_pkg::*;

  localparam int NW = 4;
  localparam int NF = NW - 1;
  localparam int ROWS = 256;

  typedef struct packed {
    logic [3:0]  idx;
    logic [47:0] value;
    logic [19:0] iters;
    logic        conv;
    logic        last;
  } weight_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_addr_i = '0;
  logic [32:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  linear_regression_gradient_descent dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the engine state.
  longint feat_mem [ROWS][NF];
  longint tgt_mem [ROWS];
  longint row_buf [NF];
  longint weights [NW];
  int unsigned rows_held;
  logic [63:0] lr_q, tol_q;
  int unsigned iter_limit;

  weight_word_t weight_q [$];
  int mismatches = 0;
  int items_used = 0;
  bit quiet = 1'b0;

  function automatic logic [63:0] mag_of(longint x);
    return x < 0 ? 64'd0 - x : x;
  endfunction

  function automatic longint sign_pack(bit neg, logic [63:0] m, int bits);
    logic [63:0] lim;
    lim = 64'd1 << (bits - 1);
    if (m == 0) return 0;
    if (!neg) begin
      if (m > lim - 1) m = lim - 1;
      return longint'(m);
    end
    if (m > lim) m = lim;
    return -longint'(m - 1) - 1;
  endfunction

  // (a * b) >> 32, magnitude rounded half up, saturating at 64 bits.
  function automatic logic [63:0] umul_q(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [96:0] r;
    p = {64'd0, a} * {64'd0, b};
    r = {1'b0, p[127:32]} + p[31];
    if (r > 97'h0_FFFF_FFFF_FFFF_FFFF) return 64'hFFFF_FFFF_FFFF_FFFF;
    return r[63:0];
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return sign_pack((a < 0) != (b < 0), umul_q(mag_of(a), mag_of(b)), 64);
  endfunction

  function automatic longint sat_add(longint a, longint b, int bits);
    logic signed [65:0] s, hi, lo;
    s = a;
    s = s + b;
    hi = (66'sd1 <<< (bits - 1)) - 66'sd1;
    lo = -(66'sd1 <<< (bits - 1));
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return longint'(s[63:0]);
  endfunction

  function automatic bit descent_iteration();
    longint grad [NW];
    longint h, err, step;
    logic [63:0] avg;
    bit all_small;
    all_small = 1'b1;
    for (int k = 0; k < NW; k++) grad[k] = 0;
    for (int j = 0; j < rows_held; j++) begin
      h = weights[0];
      for (int k = 1; k < NW; k++) h = sat_add(h, q_mul(weights[k], feat_mem[j][k-1]), 48);
      err = sat_add(h, -tgt_mem[j], 48);
      grad[0] = sat_add(grad[0], err, 64);
      for (int k = 1; k < NW; k++)
        grad[k] = sat_add(grad[k], q_mul(err, feat_mem[j][k-1]), 64);
    end
    for (int k = 0; k < NW; k++) begin
      avg = mag_of(grad[k]) / rows_held;
      step = sign_pack(grad[k] >= 0, umul_q(lr_q, avg), 48);
      weights[k] = sat_add(weights[k], step, 48);
      if (mag_of(step) > tol_q) all_small = 1'b0;
    end
    return all_small;
  endfunction

  // Applies one accepted word; returns 1 if the engine acts on it.
  function automatic bit predict_word(logic [1:0] kind, logic [3:0] idx, logic [47:0] v48);
    longint v;
    int unsigned iters;
    bit conv;
    weight_word_t w;
    v = longint'($signed(v48));
    iters = 0;
    conv = 1'b0;
    case (kind)
      KIND_FEATURE: begin
        if (idx >= NF) return 1'b0;
        row_buf[idx] = v;
      end
      KIND_TARGET: begin
        if (rows_held >= ROWS) return 1'b0;
        for (int k = 0; k < NF; k++) feat_mem[rows_held][k] = row_buf[k];
        tgt_mem[rows_held] = v;
        rows_held++;
      end
      KIND_WEIGHT: begin
        if (idx >= NW) return 1'b0;
        weights[idx] = v;
      end
      default: begin
        if (rows_held > 0) begin
          while (iters < iter_limit) begin
            iters++;
            if (descent_iteration()) begin
              conv = 1'b1;
              break;
            end
          end
        end
        rows_held = 0;
        for (int k = 0; k < NW; k++) begin
          w.idx = 4'(k);
          w.value = weights[k][47:0];
          w.iters = 20'(iters);
          w.conv = conv;
          w.last = (k == NW - 1);
          weight_q.push_back(w);
        end
      end
    endcase
    return 1'b1;
  endfunction

  task automatic send_word(logic [1:0] kind, logic [3:0] idx, longint v);
    bit rdy;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= {4'd0, v[47:0], idx};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    if (predict_word(kind, idx, v[47:0])) items_used++;
  endtask

  task automatic end_burst();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds the sender until every weight word is back and the engine has settled.
  task automatic wait_idle();
    end_burst();
    wait (weight_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [32:0] data);
    bit rdy;
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    case (addr)
      CFG_STEP_SIZE: lr_q = 64'(data);
      CFG_MAX_ITER:  iter_limit = 32'(data[19:0]);
      default:       tol_q = 64'(data);
    endcase
  endtask

  task automatic set_config(logic [32:0] lr, logic [19:0] iters, logic [32:0] tol);
    write_reg(CFG_STEP_SIZE, lr);
    write_reg(CFG_MAX_ITER, {13'd0, iters});
    write_reg(CFG_TOLERANCE, tol);
  endtask

  function automatic longint rand_value();
    longint v;
    v = longint'({$urandom, $urandom});
    return v >>> $urandom_range(16, 40);
  endfunction

  // Receiver side: random stall bursts, none once the run goes quiet.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Outputs are stable at the falling edge; a word moves at the next rising edge.
  always @(negedge clk_i) begin
    weight_word_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[3:0], m_axis_tdata_o[51:4], m_axis_tdata_o[71:52],
             m_axis_tdata_o[72], m_axis_tlast_o};
      if (weight_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected weight word %h", got);
      end else begin
        want = weight_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("weight word mismatch: idx %0d/%0d value %h/%h iters %0d/%0d conv %b/%b last %b/%b (exp/got)",
                     want.idx, got.idx, want.value, got.value, want.iters, got.iters,
                     want.conv, got.conv, want.last, got.last);
        end
      end
    end
  end

  task automatic test_empty_start_defaults();
    send_word(KIND_START, 4'd0, 0);
  endtask

  task automatic test_directed_rows();
    set_config(33'd429496730, 20'd4, 33'd4295);
    send_word(KIND_FEATURE, 4'd0, 64'sh0000_7FFF_FFFF_FFFF);
    send_word(KIND_FEATURE, 4'd1, -64'sh0000_8000_0000_0000);
    send_word(KIND_FEATURE, 4'd2, 64'sh1_0000_0000);
    send_word(KIND_FEATURE, 4'd3, 64'sh1234_5678);      // out of range, ignored
    send_word(KIND_FEATURE, 4'd15, -1);                  // out of range, ignored
    send_word(KIND_TARGET, 4'd0, 64'sh3_0000_0000);
    send_word(KIND_TARGET, 4'd7, -64'sh2_8000_0000);     // reuses the previous row
    send_word(KIND_WEIGHT, 4'd0, 64'sh0000_7FFF_FFFF_FFFF);
    send_word(KIND_WEIGHT, 4'd3, -64'sh0000_8000_0000_0000);
    send_word(KIND_WEIGHT, 4'd4, 64'sh5555);             // out of range, ignored
    send_word(KIND_WEIGHT, 4'd15, -1);
    send_word(KIND_START, 4'd9, 64'sh0000_7FFF_FFFF_FFFF);
    // Weights carry over, so they are zeroed first; a gentler problem follows.
    for (int k = 0; k < NW; k++) send_word(KIND_WEIGHT, k[3:0], 0);
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < NF; k++) send_word(KIND_FEATURE, k[3:0], longint'(r + k) <<< 32);
      send_word(KIND_TARGET, 4'd0, longint'(2 * r + 1) <<< 32);
    end
    send_word(KIND_START, 4'd0, 0);
  endtask

  task automatic test_iteration_limits();
    // A zero limit runs nothing; the widest limit converges at once with a zero rate.
    set_config(33'h1_0000_0000, 20'd0, 33'd0);
    send_word(KIND_FEATURE, 4'd0, 64'sh1_0000_0000);
    send_word(KIND_TARGET, 4'd0, 64'sh5_0000_0000);
    send_word(KIND_START, 4'd0, 0);
    set_config(33'd0, 20'hFFFFF, 33'h1_0000_0000);
    send_word(KIND_TARGET, 4'd0, -64'sh5_0000_0000);
    send_word(KIND_START, 4'd0, 0);
    set_config(33'h1_0000_0000, 20'd3, 33'd0);
    send_word(KIND_TARGET, 4'd0, 64'sh7_0000_0000);
    send_word(KIND_START, 4'd0, 0);
  endtask

  task automatic test_store_full();
    set_config(33'd42949673, 20'd1, 33'd4295);
    // Most rows reuse the held feature row; one target more than the store holds.
    for (int r = 0; r <= ROWS; r++) begin
      if (r % 64 == 0) send_word(KIND_FEATURE, 4'((r / 64) % NF), rand_value() >>> 8);
      send_word(KIND_TARGET, 4'd0, rand_value() >>> 8);
    end
    send_word(KIND_START, 4'd0, 0);
  endtask

  task automatic test_random();
    int goal;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(33'h1_0000_0000, 20'd2, 33'd0);
        1: set_config(33'd0, 20'd5, 33'h1_0000_0000);
        default: set_config({1'b0, $urandom_range(0, 32'h4000_0000)},
                            20'($urandom_range(1, 6)),
                            $urandom_range(0, 1) ? 33'($urandom_range(0, 1 << 20)) :
                                                   {1'($urandom_range(0, 1)), $urandom});
      endcase
      if (phase == 5) quiet = 1'b1;
      goal = items_used + 8;
      while (items_used < goal) begin
        if ($urandom_range(0, 6) == 0) begin
          send_word(2'($urandom), 4'($urandom), rand_value());
        end else begin
          repeat ($urandom_range(0, 2)) send_word(KIND_WEIGHT, 4'($urandom_range(0, 5)),
                                                 rand_value());
          repeat ($urandom_range(1, 5)) begin
            for (int k = 0; k < NF; k++)
              if ($urandom_range(0, 7) != 0) send_word(KIND_FEATURE, k[3:0], rand_value());
            send_word(KIND_TARGET, 4'($urandom), rand_value());
          end
          send_word(KIND_START, 4'($urandom), rand_value());
        end
      end
    end
  endtask

  initial begin
    for (int k = 0; k < NF; k++) row_buf[k] = 0;
    for (int k = 0; k < NW; k++) weights[k] = 0;
    rows_held = 0;
    lr_q = 64'(LR_RESET);
    tol_q = 64'(TOL_RESET);
    iter_limit = 32'(ITER_RESET);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_start_defaults();
    test_directed_rows();
    test_iteration_limits();
    test_store_full();
    test_random();
    end_burst();
    wait (weight_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** linear_regression_gradient_descent: PASSED **");
    end else begin
      $display("** linear_regression_gradient_descent: FAILED **");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("** linear_regression_gradient_descent: FAILED **");
    $finish;
  end

endmodule
